// ----- rtl/core/pts_pkg.sv -----
// ----------------------------------------------------------------------------
// pts_pkg
// Shared types, codes and reset constants of the periodic task scheduler.
// ----------------------------------------------------------------------------
package pts_pkg;

  localparam int MAX_TASKS     = 4;
  localparam int NUM_TASKS_DEF = 3;

  localparam int CNT_W  = 16;
  localparam int ST_W   = 2;
  localparam int TASK_W = 2;
  localparam int KIND_W = 3;
  localparam int CMD_W  = 3;
  localparam int IDX_W  = 3;
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  // commands
  localparam logic [CMD_W-1:0] CMD_TICK     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DISPATCH = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SUSPEND  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_RESUME   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_QUERY    = 3'd4;

  // task status
  localparam logic [ST_W-1:0] ST_STOP = 2'd0;
  localparam logic [ST_W-1:0] ST_RUN  = 2'd1;
  localparam logic [ST_W-1:0] ST_SUSP = 2'd2;

  // result kinds
  localparam logic [KIND_W-1:0] K_DONE     = 3'd0;
  localparam logic [KIND_W-1:0] K_DISPATCH = 3'd1;
  localparam logic [KIND_W-1:0] K_NONE     = 3'd2;
  localparam logic [KIND_W-1:0] K_STATUS   = 3'd3;
  localparam logic [KIND_W-1:0] K_CLEANUP  = 3'd4;
  localparam logic [KIND_W-1:0] K_RANGE    = 3'd5;

  typedef logic [MAX_TASKS-1:0][CNT_W-1:0] period_arr_t;

  localparam period_arr_t PERIOD_RST = {16'd0, 16'd2000, 16'd100, 16'd10};

  // one entry of the task table
  typedef struct packed {
    logic [ST_W-1:0]  st;
    logic [CNT_W-1:0] cnt;
  } ent_t;

  // sequencer to table memory
  typedef struct packed {
    logic              we;
    logic [TASK_W-1:0] waddr;
    ent_t              wdata;
    logic              re;
    logic [TASK_W-1:0] raddr;
  } mem_req_t;

endpackage

// ----- rtl/core/pts_regs.sv -----
// ----------------------------------------------------------------------------
// pts_regs
// APB register file holding the reload period of each task.
// ----------------------------------------------------------------------------
module pts_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pts_pkg::ADDR_W-1:0]     paddr,
  input  logic [pts_pkg::DATA_W-1:0]     pwdata,
  output logic [pts_pkg::DATA_W-1:0]     prdata,
  output logic                           pready,
  output pts_pkg::period_arr_t           period
);

  pts_pkg::period_arr_t              period_r;
  logic [pts_pkg::TASK_W-1:0]        reg_idx;
  logic                              wr_en;

  assign reg_idx = paddr[pts_pkg::ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign prdata  = {{(pts_pkg::DATA_W-pts_pkg::CNT_W){1'b0}}, period_r[reg_idx]};
  assign period  = period_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= pts_pkg::PERIOD_RST;
    end else if (wr_en) begin
      period_r[reg_idx] <= pwdata[pts_pkg::CNT_W-1:0];
    end
  end

endmodule

// ----- rtl/core/pts_mem.sv -----
// ----------------------------------------------------------------------------
// pts_mem
// Task table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pts_mem #(
  parameter int DEPTH = pts_pkg::NUM_TASKS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  pts_pkg::mem_req_t req,
  output pts_pkg::ent_t     rdata
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  pts_pkg::ent_t    mem_r [DEPTH];
  logic [DEPTH-1:0] vld_r;
  pts_pkg::ent_t    rdata_r;
  logic [AW-1:0]    wa;
  logic [AW-1:0]    ra;

  assign wa    = req.waddr[AW-1:0];
  assign ra    = req.raddr[AW-1:0];
  assign rdata = rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem_r[wa] <= req.wdata;
    end
  end

  // an entry never written reads as zero count, stop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (req.we) begin
      vld_r[wa] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata_r <= vld_r[ra] ? mem_r[ra] : '0;
    end
  end

endmodule

// ----- rtl/core/pts_seq.sv -----
// ----------------------------------------------------------------------------
// pts_seq
// Command sequencer: reads, updates and writes back task entries, builds beats.
// ----------------------------------------------------------------------------
module pts_seq #(
  parameter int NUM_TASKS = pts_pkg::NUM_TASKS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [pts_pkg::CMD_W-1:0]   in_cmd,
  input  logic [pts_pkg::IDX_W-1:0]   in_task_index,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [pts_pkg::KIND_W-1:0]  out_kind,
  output logic [pts_pkg::TASK_W-1:0]  out_task_number,
  output logic [pts_pkg::ST_W-1:0]    out_task_status,
  output logic                        out_last,
  input  pts_pkg::period_arr_t        period,
  output pts_pkg::mem_req_t           mem_req,
  input  pts_pkg::ent_t               mem_rdata
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MOD  = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  localparam logic [pts_pkg::TASK_W-1:0] LAST_TASK = pts_pkg::TASK_W'(NUM_TASKS - 1);
  localparam logic [pts_pkg::IDX_W-1:0]  NUM_IDX   = pts_pkg::IDX_W'(NUM_TASKS);

  logic [1:0]                   state_r, state_nxt;
  logic [pts_pkg::CMD_W-1:0]    cmd_r, cmd_nxt;
  logic [pts_pkg::TASK_W-1:0]   addr_r, addr_nxt;
  logic [pts_pkg::KIND_W-1:0]   hold_kind_r, hold_kind_nxt;
  logic [pts_pkg::TASK_W-1:0]   hold_num_r, hold_num_nxt;
  logic [pts_pkg::ST_W-1:0]     hold_st_r, hold_st_nxt;
  logic                         hold_disp_r, hold_disp_nxt;

  logic                         out_valid_r;
  logic [pts_pkg::KIND_W-1:0]   out_kind_r;
  logic [pts_pkg::TASK_W-1:0]   out_num_r;
  logic [pts_pkg::ST_W-1:0]     out_st_r;
  logic                         out_last_r;

  logic                         push_ok;
  logic                         push;
  logic [pts_pkg::KIND_W-1:0]   push_kind;
  logic [pts_pkg::TASK_W-1:0]   push_num;
  logic [pts_pkg::ST_W-1:0]     push_st;
  logic                         push_last;
  logic                         advance;
  logic [pts_pkg::CNT_W-1:0]    cnt_dec;
  logic [pts_pkg::CNT_W-1:0]    period_sel;
  logic [pts_pkg::TASK_W-1:0]   addr_inc;
  logic                         in_range;
  pts_pkg::ent_t                ent_new;

  assign in_ready   = (state_r == S_IDLE);
  assign push_ok    = !out_valid_r || out_ready;
  assign cnt_dec    = (mem_rdata.cnt != '0) ? mem_rdata.cnt - 1'b1 : '0;
  assign period_sel = period[addr_r];
  assign addr_inc   = addr_r + 1'b1;
  assign in_range   = (in_task_index < NUM_IDX);

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    addr_nxt      = addr_r;
    hold_kind_nxt = hold_kind_r;
    hold_num_nxt  = hold_num_r;
    hold_st_nxt   = hold_st_r;
    hold_disp_nxt = hold_disp_r;
    mem_req       = '0;
    push          = 1'b0;
    push_kind     = hold_kind_r;
    push_num      = hold_num_r;
    push_st       = hold_st_r;
    push_last     = 1'b1;
    advance       = 1'b0;
    ent_new       = mem_rdata;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt       = in_cmd;
          hold_num_nxt  = '0;
          hold_st_nxt   = pts_pkg::ST_STOP;
          hold_disp_nxt = 1'b0;
          case (in_cmd)
            pts_pkg::CMD_TICK, pts_pkg::CMD_DISPATCH: begin
              mem_req.re    = 1'b1;
              mem_req.raddr = '0;
              addr_nxt      = '0;
              hold_kind_nxt = (in_cmd == pts_pkg::CMD_TICK) ? pts_pkg::K_DONE
                                                             : pts_pkg::K_NONE;
              state_nxt     = S_MOD;
            end
            pts_pkg::CMD_SUSPEND, pts_pkg::CMD_RESUME, pts_pkg::CMD_QUERY: begin
              if (in_range) begin
                mem_req.re    = 1'b1;
                mem_req.raddr = in_task_index[pts_pkg::TASK_W-1:0];
                addr_nxt      = in_task_index[pts_pkg::TASK_W-1:0];
                state_nxt     = S_MOD;
              end else begin
                hold_kind_nxt = pts_pkg::K_RANGE;
                state_nxt     = S_FIN;
              end
            end
            default: begin
              hold_kind_nxt = pts_pkg::K_DONE;
              state_nxt     = S_FIN;
            end
          endcase
        end
      end

      S_MOD: begin
        mem_req.waddr = addr_r;
        case (cmd_r)
          pts_pkg::CMD_TICK: begin
            if (mem_rdata.st != pts_pkg::ST_SUSP) begin
              if (cnt_dec == '0) begin
                ent_new.st  = pts_pkg::ST_RUN;
                ent_new.cnt = period_sel;
              end else begin
                ent_new.cnt = cnt_dec;
              end
              mem_req.we = 1'b1;
            end
            advance = 1'b1;
          end
          pts_pkg::CMD_DISPATCH: begin
            if (mem_rdata.st == pts_pkg::ST_RUN) begin
              // flush the previous dispatch beat, it is not the last one
              if (hold_disp_r) begin
                push      = push_ok;
                push_kind = pts_pkg::K_DISPATCH;
                push_last = 1'b0;
              end
              if (!hold_disp_r || push_ok) begin
                ent_new.st    = pts_pkg::ST_STOP;
                mem_req.we    = 1'b1;
                hold_kind_nxt = pts_pkg::K_DISPATCH;
                hold_num_nxt  = addr_r;
                hold_disp_nxt = 1'b1;
                advance       = 1'b1;
              end
            end else begin
              advance = 1'b1;
            end
          end
          pts_pkg::CMD_SUSPEND: begin
            ent_new.st    = pts_pkg::ST_SUSP;
            ent_new.cnt   = period_sel;
            mem_req.we    = 1'b1;
            hold_kind_nxt = pts_pkg::K_CLEANUP;
            hold_num_nxt  = addr_r;
            state_nxt     = S_FIN;
          end
          pts_pkg::CMD_RESUME: begin
            ent_new.st    = pts_pkg::ST_STOP;
            mem_req.we    = 1'b1;
            hold_kind_nxt = pts_pkg::K_DONE;
            hold_num_nxt  = addr_r;
            state_nxt     = S_FIN;
          end
          pts_pkg::CMD_QUERY: begin
            hold_kind_nxt = pts_pkg::K_STATUS;
            hold_num_nxt  = addr_r;
            hold_st_nxt   = mem_rdata.st;
            state_nxt     = S_FIN;
          end
          default: begin
            state_nxt = S_FIN;
          end
        endcase
        if (advance) begin
          if (addr_r == LAST_TASK) begin
            state_nxt = S_FIN;
          end else begin
            addr_nxt      = addr_inc;
            mem_req.re    = 1'b1;
            mem_req.raddr = addr_inc;
          end
        end
      end

      S_FIN: begin
        push = push_ok;
        if (push_ok) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    mem_req.wdata = ent_new;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      hold_disp_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hold_disp_r <= hold_disp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    addr_r      <= addr_nxt;
    hold_kind_r <= hold_kind_nxt;
    hold_num_r  <= hold_num_nxt;
    hold_st_r   <= hold_st_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_kind_r <= push_kind;
      out_num_r  <= push_num;
      out_st_r   <= push_st;
      out_last_r <= push_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_task_number = out_num_r;
  assign out_task_status = out_st_r;
  assign out_last        = out_last_r;

  a_we_in_mod: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.we |-> (state_r == S_MOD))
    else $error("table written outside the modify step");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!out_valid_r || out_ready))
    else $error("beat pushed over an untaken beat");

  a_hold_kind: assert property (@(posedge clk) disable iff (!rst_n)
    hold_disp_r |-> (hold_kind_r == pts_pkg::K_DISPATCH))
    else $error("held dispatch beat has the wrong kind");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r != S_IDLE))
    else $error("sequencer idle right after an accepted command");

  a_fin_last: assert property (@(posedge clk) disable iff (!rst_n)
    (push && state_r == S_FIN) |=> out_last)
    else $error("closing beat not marked last");

endmodule

// ----- rtl/core/periodic_task_scheduler.sv -----
// ----------------------------------------------------------------------------
// periodic_task_scheduler
// Time-triggered cooperative scheduler: per-task countdown and status table.
// ----------------------------------------------------------------------------
// Sequencing: tick and dispatch accept, then do one read-modify-write per
//   task through the table memory, then send a closing beat; suspend, resume
//   and query touch one in-range entry; other commands only close.
// Flow: no new command until the last closes; each holds in its closing step,
//   and a dispatch also mid-walk, while an earlier beat waits.
// Reset (synchronous, rst_n low): periods return to 10/100/2000/0, every
//   task reads as count zero and stop, no beat pending; no clearing pass.
// ----------------------------------------------------------------------------
module periodic_task_scheduler #(
  parameter int NUM_TASKS = pts_pkg::NUM_TASKS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // command channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [pts_pkg::CMD_W-1:0]   in_cmd,
  input  logic [pts_pkg::IDX_W-1:0]   in_task_index,
  // result channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [pts_pkg::KIND_W-1:0]  out_kind,
  output logic [pts_pkg::TASK_W-1:0]  out_task_number,
  output logic [pts_pkg::ST_W-1:0]    out_task_status,
  output logic                        out_last,
  // configuration (APB)
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pts_pkg::ADDR_W-1:0]  paddr,
  input  logic [pts_pkg::DATA_W-1:0]  pwdata,
  output logic [pts_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  pts_pkg::period_arr_t period;
  pts_pkg::mem_req_t    mem_req;
  pts_pkg::ent_t        mem_rdata;

  // Period registers: one 16-bit reload count per task slot, all four kept
  // even when fewer tasks are built.
  pts_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .period  (period)
  );

  // Task table: status and countdown per task, registered read data.
  pts_mem #(
    .DEPTH (NUM_TASKS)
  ) u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  // Sequencer: walks the table for tick and dispatch (reading the next
  // entry while the current one is written back), touches a single entry
  // for suspend, resume and query, and drives the output beat register.
  // A dispatch beat is held back until the next one or the close, so the last one can be flagged.
  pts_seq #(
    .NUM_TASKS (NUM_TASKS)
  ) u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cmd          (in_cmd),
    .in_task_index   (in_task_index),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_task_number (out_task_number),
    .out_task_status (out_task_status),
    .out_last        (out_last),
    .period          (period),
    .mem_req         (mem_req),
    .mem_rdata       (mem_rdata)
  );

endmodule

// ----- tb/periodic_task_scheduler_test.sv -----
// ----------------------------------------------------------------------------
// periodic_task_scheduler_test
// Self-checking bench for the periodic task scheduler: a directed table, then
// random command bursts over several period settings, checked beat by beat.
// ----------------------------------------------------------------------------
module periodic_task_scheduler_test;

  localparam int TASKS      = pts_pkg::NUM_TASKS_DEF;
  localparam int RUN_LIMIT  = 400000;
  // covers a tick or dispatch walk over all tasks; leave margin before a register write
  localparam int SETTLE     = TASKS + 8;
  localparam int HOLD_LEN   = 80;
  localparam int PHASES     = 5;
  localparam int PHASE_LEN  = 58;
  localparam int SHOW_MAX   = 10;

  // command codes the block treats as no-ops
  localparam logic [pts_pkg::CMD_W-1:0] CMD_RSVD5 = 3'd5;
  localparam logic [pts_pkg::CMD_W-1:0] CMD_RSVD7 = 3'd7;

  typedef struct packed {
    logic [pts_pkg::KIND_W-1:0] kind;
    logic [pts_pkg::TASK_W-1:0] num;
    logic [pts_pkg::ST_W-1:0]   st;
    logic                       last;
  } beat_t;

  // one row of the directed table; want is used only when pinned is set
  typedef struct packed {
    logic [pts_pkg::CMD_W-1:0] cmd;
    logic [pts_pkg::IDX_W-1:0] idx;
    logic                      pinned;
    beat_t                     want;
  } row_t;

  localparam int DIR_ROWS = 26;
  localparam beat_t NO_BEAT = '0;

  // Reset periods are 10/100/2000, every countdown is zero and every task
  // stops. The first tick therefore makes all three tasks ready at once.
  localparam row_t DIRECTED [DIR_ROWS] = '{
    '{pts_pkg::CMD_QUERY,    3'd0, 1'b1,
      '{pts_pkg::K_STATUS,  2'd0, pts_pkg::ST_STOP, 1'b1}},
    '{pts_pkg::CMD_TICK,     3'd5, 1'b1,
      '{pts_pkg::K_DONE,    2'd0, pts_pkg::ST_STOP, 1'b1}},
    '{pts_pkg::CMD_QUERY,    3'd0, 1'b1,
      '{pts_pkg::K_STATUS,  2'd0, pts_pkg::ST_RUN,  1'b1}},
    '{pts_pkg::CMD_QUERY,    3'd2, 1'b1,
      '{pts_pkg::K_STATUS,  2'd2, pts_pkg::ST_RUN,  1'b1}},
    '{pts_pkg::CMD_DISPATCH, 3'd0, 1'b0, NO_BEAT},
    '{pts_pkg::CMD_DISPATCH, 3'd7, 1'b1,
      '{pts_pkg::K_NONE,    2'd0, pts_pkg::ST_STOP, 1'b1}},
    '{pts_pkg::CMD_SUSPEND,  3'd1, 1'b1,
      '{pts_pkg::K_CLEANUP, 2'd1, pts_pkg::ST_STOP, 1'b1}},
    '{pts_pkg::CMD_QUERY,    3'd1, 1'b1,
      '{pts_pkg::K_STATUS,  2'd1, pts_pkg::ST_SUSP, 1'b1}},
    '{pts_pkg::CMD_TICK,     3'd0, 1'b1,
      '{pts_pkg::K_DONE,    2'd0, pts_pkg::ST_STOP, 1'b1}},
    '{pts_pkg::CMD_RESUME,   3'd1, 1'b1,
      '{pts_pkg::K_DONE,    2'd1, pts_pkg::ST_STOP, 1'b1}},
    '{pts_pkg::CMD_QUERY,    3'd1, 1'b1,
      '{pts_pkg::K_STATUS,  2'd1, pts_pkg::ST_STOP, 1'b1}},
    // addresses past the last built task
    '{pts_pkg::CMD_SUSPEND,  3'd7, 1'b1,
      '{pts_pkg::K_RANGE,   2'd0, pts_pkg::ST_STOP, 1'b1}},
    '{pts_pkg::CMD_RESUME,   3'd3, 1'b1,
      '{pts_pkg::K_RANGE,   2'd0, pts_pkg::ST_STOP, 1'b1}},
    '{pts_pkg::CMD_QUERY,    3'd4, 1'b1,
      '{pts_pkg::K_RANGE,   2'd0, pts_pkg::ST_STOP, 1'b1}},
    // unknown commands answer done and leave the table alone
    '{CMD_RSVD5,             3'd6, 1'b1,
      '{pts_pkg::K_DONE,    2'd0, pts_pkg::ST_STOP, 1'b1}},
    '{CMD_RSVD7,             3'd7, 1'b1,
      '{pts_pkg::K_DONE,    2'd0, pts_pkg::ST_STOP, 1'b1}},
    // count task 0 down to zero, then collect it
    '{pts_pkg::CMD_TICK,     3'd0, 1'b0, NO_BEAT},
    '{pts_pkg::CMD_TICK,     3'd1, 1'b0, NO_BEAT},
    '{pts_pkg::CMD_TICK,     3'd2, 1'b0, NO_BEAT},
    '{pts_pkg::CMD_TICK,     3'd3, 1'b0, NO_BEAT},
    '{pts_pkg::CMD_TICK,     3'd4, 1'b0, NO_BEAT},
    '{pts_pkg::CMD_TICK,     3'd5, 1'b0, NO_BEAT},
    '{pts_pkg::CMD_TICK,     3'd6, 1'b0, NO_BEAT},
    '{pts_pkg::CMD_TICK,     3'd7, 1'b0, NO_BEAT},
    '{pts_pkg::CMD_TICK,     3'd0, 1'b0, NO_BEAT},
    '{pts_pkg::CMD_DISPATCH, 3'd2, 1'b0, NO_BEAT}
  };

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_ready;
  logic [pts_pkg::CMD_W-1:0]    in_cmd;
  logic [pts_pkg::IDX_W-1:0]    in_task_index;
  logic                         out_valid;
  logic                         out_ready;
  logic [pts_pkg::KIND_W-1:0]   out_kind;
  logic [pts_pkg::TASK_W-1:0]   out_task_number;
  logic [pts_pkg::ST_W-1:0]     out_task_status;
  logic                         out_last;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [pts_pkg::ADDR_W-1:0]   paddr;
  logic [pts_pkg::DATA_W-1:0]   pwdata;
  logic [pts_pkg::DATA_W-1:0]   prdata;
  logic                         pready;

  periodic_task_scheduler #(
    .NUM_TASKS(TASKS)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cmd         (in_cmd),
    .in_task_index  (in_task_index),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_task_number(out_task_number),
    .out_task_status(out_task_status),
    .out_last       (out_last),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Scheduler shadow: periods, countdowns and status per task, plus the beats
  // still owed by the block in the order it must send them.
  // ---------------------------------------------------------------------------
  logic [pts_pkg::CNT_W-1:0] period_shadow [pts_pkg::MAX_TASKS];
  logic [pts_pkg::CNT_W-1:0] count_shadow  [TASKS];
  logic [pts_pkg::ST_W-1:0]  state_shadow  [TASKS];
  beat_t                     owed_beats [$];

  // a pinned row replaces the computed beat with the one typed in the table
  bit               pin_on;
  beat_t            pin_beat;

  int  cycles;
  int  mismatches;
  int  cmds_taken;
  int  dispatch_beats;
  int  status_beats;
  int  burst_left;
  bit  no_gaps;
  bit  long_hold;

  function automatic beat_t mk_beat(logic [pts_pkg::KIND_W-1:0] kind,
                                    logic [pts_pkg::TASK_W-1:0] num,
                                    logic [pts_pkg::ST_W-1:0] st);
    beat_t b;
    b.kind = kind;
    b.num  = num;
    b.st   = st;
    b.last = 1'b1;
    return b;
  endfunction

  // Apply one command to the shadow and queue the beats it owes.
  function automatic void run_scheduler(logic [pts_pkg::CMD_W-1:0] cmd,
                                        logic [pts_pkg::IDX_W-1:0] idx);
    beat_t made [$];
    beat_t b;
    logic [pts_pkg::TASK_W-1:0] t;
    t = idx[pts_pkg::TASK_W-1:0];
    case (cmd)
      pts_pkg::CMD_TICK: begin
        for (int i = 0; i < TASKS; i++) begin
          if (state_shadow[i] != pts_pkg::ST_SUSP) begin
            if (count_shadow[i] != '0) count_shadow[i] = count_shadow[i] - 1'b1;
            // reload on reaching zero; a zero period fires on every tick
            if (count_shadow[i] == '0) begin
              state_shadow[i] = pts_pkg::ST_RUN;
              count_shadow[i] = period_shadow[i];
            end
          end
        end
        made.push_back(mk_beat(pts_pkg::K_DONE, '0, pts_pkg::ST_STOP));
      end
      pts_pkg::CMD_DISPATCH: begin
        for (int i = 0; i < TASKS; i++) begin
          if (state_shadow[i] == pts_pkg::ST_RUN) begin
            state_shadow[i] = pts_pkg::ST_STOP;
            b = mk_beat(pts_pkg::K_DISPATCH, pts_pkg::TASK_W'(i), pts_pkg::ST_STOP);
            b.last = 1'b0;
            made.push_back(b);
          end
        end
        if (made.size() == 0) begin
          made.push_back(mk_beat(pts_pkg::K_NONE, '0, pts_pkg::ST_STOP));
        end else begin
          // mark the final dispatch beat
          b = made.pop_back();
          b.last = 1'b1;
          made.push_back(b);
        end
      end
      pts_pkg::CMD_SUSPEND, pts_pkg::CMD_RESUME, pts_pkg::CMD_QUERY: begin
        if (idx >= TASKS) begin
          made.push_back(mk_beat(pts_pkg::K_RANGE, '0, pts_pkg::ST_STOP));
        end else if (cmd == pts_pkg::CMD_SUSPEND) begin
          count_shadow[t] = period_shadow[t];
          state_shadow[t] = pts_pkg::ST_SUSP;
          made.push_back(mk_beat(pts_pkg::K_CLEANUP, t, pts_pkg::ST_STOP));
        end else if (cmd == pts_pkg::CMD_RESUME) begin
          state_shadow[t] = pts_pkg::ST_STOP;
          made.push_back(mk_beat(pts_pkg::K_DONE, t, pts_pkg::ST_STOP));
        end else begin
          made.push_back(mk_beat(pts_pkg::K_STATUS, t, state_shadow[t]));
        end
      end
      default: made.push_back(mk_beat(pts_pkg::K_DONE, '0, pts_pkg::ST_STOP));
    endcase
    if (pin_on) begin
      owed_beats.push_back(pin_beat);
    end else begin
      foreach (made[i]) owed_beats.push_back(made[i]);
    end
  endfunction

  function automatic void log_mismatch(string what, beat_t want, beat_t got);
    mismatches++;
    if (mismatches <= SHOW_MAX) begin
      $display("mismatch (%s) at cycle %0d: expected kind=%0d task=%0d status=%0d last=%0d,",
               what, cycles, want.kind, want.num, want.st, want.last);
      $display("  got kind=%0d task=%0d status=%0d last=%0d",
               got.kind, got.num, got.st, got.last);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Watchdog: end the run if it never drains.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    cycles++;
    if (cycles > RUN_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still owed", cycles, owed_beats.size());
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on every accepted command, check every accepted beat.
  // Predict first so a beat leaving on the same edge still finds its entry.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    beat_t got;
    beat_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        run_scheduler(in_cmd, in_task_index);
        cmds_taken++;
      end
      if (out_valid && out_ready) begin
        got = '{out_kind, out_task_number, out_task_status, out_last};
        if (got.kind == pts_pkg::K_DISPATCH) dispatch_beats++;
        if (got.kind == pts_pkg::K_STATUS) status_beats++;
        if (owed_beats.size() == 0) begin
          log_mismatch("beat with nothing owed", NO_BEAT, got);
        end else begin
          want = owed_beats.pop_front();
          if (got !== want) log_mismatch("wrong field", want, got);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result side: stall on a pattern of its own, switching between always
  // ready, light stalls and heavy stalls. On request hold off for a long
  // stretch so the block backs up into its command channel.
  // ---------------------------------------------------------------------------
  initial begin
    int seg_left;
    int rx_mode;
    seg_left  = 0;
    rx_mode   = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (HOLD_LEN) @(negedge clk);
        long_hold = 1'b0;
      end else begin
        if (seg_left == 0) begin
          rx_mode  = $urandom_range(0, 2);
          seg_left = $urandom_range(8, 60);
        end
        seg_left--;
        case (rx_mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(0, 3) != 0);
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Command side
  // ---------------------------------------------------------------------------

  // Drop valid for a random gap at the start of most bursts, unless gaps are off.
  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 10);
      if (!no_gaps && $urandom_range(0, 3) != 0) begin
        gap = $urandom_range(1, 6);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
  endtask

  // Offer one command and hold it until the block takes it.
  task automatic send_cmd(logic [pts_pkg::CMD_W-1:0] cmd, logic [pts_pkg::IDX_W-1:0] idx,
                          bit pinned, beat_t want);
    pace_sender();
    @(negedge clk);
    pin_on        = pinned;
    pin_beat      = want;
    in_valid      <= 1'b1;
    in_cmd        <= cmd;
    in_task_index <= idx;
    do @(posedge clk); while (!in_ready);
  endtask

  // Random command: mostly ticks and dispatches, mostly in-range addresses.
  task automatic send_random_cmd();
    int pick;
    logic [pts_pkg::CMD_W-1:0] cmd;
    logic [pts_pkg::IDX_W-1:0] idx;
    pick = $urandom_range(0, 99);
    if (pick < 45)      cmd = pts_pkg::CMD_TICK;
    else if (pick < 70) cmd = pts_pkg::CMD_DISPATCH;
    else if (pick < 78) cmd = pts_pkg::CMD_SUSPEND;
    else if (pick < 88) cmd = pts_pkg::CMD_RESUME;
    else if (pick < 96) cmd = pts_pkg::CMD_QUERY;
    else                cmd = pts_pkg::CMD_W'($urandom_range(CMD_RSVD5, CMD_RSVD7));
    if ($urandom_range(0, 4) == 0) idx = pts_pkg::IDX_W'($urandom_range(TASKS, 7));
    else                           idx = pts_pkg::IDX_W'($urandom_range(0, TASKS - 1));
    send_cmd(cmd, idx, 1'b0, NO_BEAT);
  endtask

  // Stop offering, wait until every owed beat is back, then let the block settle.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (owed_beats.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Write one period register over APB, then read it back.
  task automatic set_period(int idx, logic [pts_pkg::CNT_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= pts_pkg::ADDR_W'(4 * idx);
    // upper bits are junk the register must drop
    pwdata  <= {16'($urandom()), value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    period_shadow[idx] = value;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    psel    <= 1'b1;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[pts_pkg::CNT_W-1:0] !== value) begin
      mismatches++;
      if (mismatches <= SHOW_MAX)
        $display("mismatch (period readback) reg %0d: expected %0d, got %0d",
                 idx, value, prdata[pts_pkg::CNT_W-1:0]);
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    logic [pts_pkg::CNT_W-1:0] val;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_cmd        = pts_pkg::CMD_TICK;
    in_task_index = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    pin_on        = 1'b0;
    pin_beat      = NO_BEAT;
    cycles        = 0;
    mismatches    = 0;
    cmds_taken    = 0;
    dispatch_beats = 0;
    status_beats  = 0;
    burst_left    = 0;
    no_gaps       = 1'b0;
    long_hold     = 1'b0;
    for (int i = 0; i < pts_pkg::MAX_TASKS; i++) period_shadow[i] = pts_pkg::PERIOD_RST[i];
    for (int i = 0; i < TASKS; i++) begin
      count_shadow[i] = '0;
      state_shadow[i] = pts_pkg::ST_STOP;
    end

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // walk the directed table with the reset periods
    foreach (DIRECTED[r]) send_cmd(DIRECTED[r].cmd, DIRECTED[r].idx, DIRECTED[r].pinned,
                                   DIRECTED[r].want);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      for (int i = 0; i < pts_pkg::MAX_TASKS; i++) begin
        case (p)
          0:       val = pts_pkg::CNT_W'(i);                  // 0,1,2,3: task 0 every tick
          1:       val = '1;                                  // longest periods
          2:       val = pts_pkg::CNT_W'($urandom_range(1, 7));
          3:       val = (i == pts_pkg::MAX_TASKS - 1) ? '1 : '0; // all built tasks every tick
          default: val = (i == 0) ? pts_pkg::CNT_W'($urandom_range(0, 5)) :
                         (i == 1) ? pts_pkg::CNT_W'($urandom_range(0, 300)) :
                                    pts_pkg::CNT_W'($urandom());
        endcase
        set_period(i, val);
      end

      if (p == 1) begin
        // hold the result side off while commands keep coming back to back
        long_hold = 1'b1;
        no_gaps   = 1'b1;
        repeat (15) send_random_cmd();
        no_gaps   = 1'b0;
      end

      for (int n = 0; n < PHASE_LEN; n++) begin
        // turn gaps off for some stretches
        if (n % 20 == 0) no_gaps = ($urandom_range(0, 2) == 0);
        send_random_cmd();
      end
      no_gaps = 1'b0;
    end

    drain();
    $display("ran %0d commands over %0d period settings plus reset values", cmds_taken, PHASES);
    $display("saw %0d dispatch beats and %0d status replies", dispatch_beats, status_beats);
    if (mismatches == 0 && owed_beats.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- periodic_task_scheduler.f -----
rtl/core/pts_pkg.sv
rtl/core/pts_regs.sv
rtl/core/pts_mem.sv
rtl/core/pts_seq.sv
rtl/core/periodic_task_scheduler.sv
tb/periodic_task_scheduler_test.sv
